// ===== hdl/assert_macros.svh =====
// Assertion macros used by the evaluator unit RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Check a consequence in the same cycle
`define ASSERT_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Check a consequence in the next cycle
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== hdl/spe_pkg.sv =====
// Types and constants of the speed profile position evaluator
`timescale 1ns / 1ps

package spe_pkg;

  localparam int unsigned FRAC_W  = 17;
  localparam logic [17:0] ONE_Q16 = 18'h10000;
  localparam logic [17:0] TWO_Q16 = 18'h20000;

  typedef enum logic [2:0] {
    REG_START_SPEED    = 3'd0,
    REG_MAX_ACCEL      = 3'd1,
    REG_ACCEL_TIME     = 3'd2,
    REG_DECEL_TIME     = 3'd3,
    REG_TOTAL_TIME     = 3'd4,
    REG_TOTAL_DISTANCE = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic              linear_mode;
    logic [FRAC_W-1:0] time_fraction;
  } in_item_t;

  typedef struct packed {
    logic [FRAC_W-1:0] distance_fraction;
    logic              out_of_range;
  } out_item_t;

  typedef struct packed {
    logic              byp;
    logic [FRAC_W-1:0] frac;
  } ctx_t;

  typedef struct packed {
    ctx_t              ctx;
    logic              neg;
    logic              sat;
    logic [33:0]       rem;
    logic [FRAC_W-1:0] quo;
  } div_t;

endpackage

// ===== hdl/speed_profile_position_evaluator_unit.sv =====
// Top level: pipelined position evaluator for a planned three-phase speed profile
//
// Usage:
//   Configure the profile over the APB port (start speed, acceleration,
//   signed first and last phase times, total time, total distance) while
//   no request is in flight. Each input request carries linear_mode and a
//   Q1.16 time fraction; each produces exactly one result with the Q1.16
//   travelled distance fraction and an out_of_range flag.
//   Throughput: one request per clock cycle while the receiver does not stall.
//   The pipeline: eight stages of timing, multiply and sum work, then a 17-stage
//   restoring divider (one quotient bit per stage), then the snap stage.
//   Reset clears the configuration and the valid bits, which empties the pipeline.
//   When the receiver stalls while a result is shown, the whole pipeline
//   holds and in_stall rises; nothing is dropped or repeated.
//   Linear mode or a zero distance passes the fraction through, clamped.
`timescale 1ns / 1ps

module speed_profile_position_evaluator_unit #(
  parameter int SNAP_TOLERANCE = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  spe_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output spe_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import spe_pkg::*;

  `include "assert_macros.svh"

  localparam int          DIV_STG = FRAC_W;
  localparam int          NSTG    = 8 + DIV_STG + 1;
  localparam logic [17:0] TOL     = 18'(SNAP_TOLERANCE);
  localparam logic [17:0] ONE_TOL = 18'(int'(ONE_Q16) + SNAP_TOLERANCE);

  function automatic logic signed [51:0] sgn52(input logic neg, input logic [50:0] m);
    logic signed [51:0] v;
    v = $signed({1'b0, m});
    return neg ? -v : v;
  endfunction

  // configuration
  logic [23:0] start_speed;
  logic [23:0] max_accel;
  logic [31:0] accel_time;
  logic [31:0] decel_time;
  logic [31:0] total_time;
  logic [31:0] total_distance;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_speed    <= '0;
      max_accel      <= '0;
      accel_time     <= '0;
      decel_time     <= '0;
      total_time     <= '0;
      total_distance <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_START_SPEED:    start_speed    <= pwdata[23:0];
        REG_MAX_ACCEL:      max_accel      <= pwdata[23:0];
        REG_ACCEL_TIME:     accel_time     <= pwdata;
        REG_DECEL_TIME:     decel_time     <= pwdata;
        REG_TOTAL_TIME:     total_time     <= pwdata;
        REG_TOTAL_DISTANCE: total_distance <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_START_SPEED:    prdata = {8'd0, start_speed};
      REG_MAX_ACCEL:      prdata = {8'd0, max_accel};
      REG_ACCEL_TIME:     prdata = accel_time;
      REG_DECEL_TIME:     prdata = decel_time;
      REG_TOTAL_TIME:     prdata = total_time;
      REG_TOTAL_DISTANCE: prdata = total_distance;
      default:            prdata = '0;
    endcase
  end

  // pipeline control
  logic            adv;
  logic [NSTG-1:0] vld;

  assign adv      = !(vld[NSTG-1] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // stage 1: elapsed time, first-phase time, speed change
  logic [31:0] d1_c;
  logic [48:0] p_el;
  logic [55:0] p_dv;
  ctx_t        s1_ctx;
  logic [32:0] s1_el;
  logic [31:0] s1_d1;
  logic [31:0] s1_dv;

  assign d1_c = accel_time[31] ? (~accel_time + 32'd1) : accel_time;
  assign p_el = 49'(in_item.time_fraction) * 49'(total_time);
  assign p_dv = 56'(max_accel) * 56'(d1_c);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctx.byp  <= in_item.linear_mode || (total_distance == '0);
      s1_ctx.frac <= in_item.time_fraction;
      s1_el       <= p_el[48:16];
      s1_d1       <= d1_c;
      s1_dv       <= p_dv[55:24];
    end
  end

  // stage 2: middle speed, phase bounds, phase choice
  logic [31:0]        d3_c;
  logic signed [33:0] vmid_c;
  logic signed [33:0] e12_c;
  logic signed [34:0] d2_c;
  logic               ph0_c;
  ctx_t               s2_ctx;
  logic [32:0]        s2_el;
  logic [31:0]        s2_d1;
  logic signed [34:0] s2_d2;
  logic signed [33:0] s2_e12;
  logic signed [33:0] s2_vmid;
  logic               s2_ph0;
  logic               s2_ph1;

  assign d3_c   = decel_time[31] ? (~decel_time + 32'd1) : decel_time;
  assign vmid_c = accel_time[31] ? $signed(34'(start_speed) - 34'(s1_dv))
                                 : $signed(34'(start_speed) + 34'(s1_dv));
  assign e12_c  = $signed(34'(total_time) - 34'(d3_c));
  assign d2_c   = 35'(e12_c) - $signed(35'(s1_d1));
  assign ph0_c  = s1_el < 33'(s1_d1);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctx  <= s1_ctx;
      s2_el   <= s1_el;
      s2_d1   <= s1_d1;
      s2_d2   <= d2_c;
      s2_e12  <= e12_c;
      s2_vmid <= vmid_c;
      s2_ph0  <= ph0_c;
      s2_ph1  <= !ph0_c && ($signed(35'(s1_el)) < 35'(e12_c));
    end
  end

  // stage 3: phase times and saturated magnitudes
  logic [32:0]        ta_c;
  logic signed [34:0] tb_c;
  logic [34:0]        mb_c;
  logic signed [34:0] tc_c;
  logic [33:0]        vmag_c;
  logic               ph2_c;
  ctx_t               s3_ctx;
  logic [31:0]        s3_tma;
  logic [31:0]        s3_tmb;
  logic [31:0]        s3_tmc;
  logic [31:0]        s3_vm;
  logic               s3_vneg;
  logic               s3_bneg;
  logic               s3_qc;

  assign ph2_c  = !s2_ph0 && !s2_ph1;
  assign ta_c   = s2_ph0 ? s2_el : 33'(s2_d1);
  assign tb_c   = s2_ph1 ? $signed(35'(s2_el) - 35'(s2_d1)) : s2_d2;
  assign mb_c   = tb_c[34] ? 35'(-tb_c) : 35'(tb_c);
  assign tc_c   = $signed(35'(s2_el)) - 35'(s2_e12);
  assign vmag_c = s2_vmid[33] ? 34'(-s2_vmid) : 34'(s2_vmid);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ctx  <= s2_ctx;
      s3_tma  <= ta_c[32] ? '1 : ta_c[31:0];
      if (s2_ph0) begin
        s3_tmb <= '0;
      end else begin
        s3_tmb <= (|mb_c[34:32]) ? '1 : mb_c[31:0];
      end
      if (ph2_c) begin
        s3_tmc <= (|tc_c[34:32]) ? '1 : tc_c[31:0];
      end else begin
        s3_tmc <= '0;
      end
      s3_vm   <= (|vmag_c[33:32]) ? '1 : vmag_c[31:0];
      s3_vneg <= s2_vmid[33];
      s3_bneg <= s2_vmid[33] != tb_c[34];
      s3_qc   <= ph2_c && (decel_time != '0);
    end
  end

  // stage 4: linear terms and first acceleration products
  logic [55:0] pla_c;
  logic [55:0] pqa_c;
  logic [63:0] plb_c;
  logic [63:0] plc_c;
  logic [55:0] pqc_c;
  ctx_t        s4_ctx;
  logic [39:0] s4_lina;
  logic [31:0] s4_qa;
  logic [47:0] s4_linb;
  logic [47:0] s4_linc;
  logic [31:0] s4_qc;
  logic [31:0] s4_tma;
  logic [31:0] s4_tmc;
  logic        s4_vneg;
  logic        s4_bneg;
  logic        s4_qcon;

  assign pla_c = 56'(start_speed) * 56'(s3_tma);
  assign pqa_c = 56'(max_accel) * 56'(s3_tma);
  assign plb_c = 64'(s3_vm) * 64'(s3_tmb);
  assign plc_c = 64'(s3_vm) * 64'(s3_tmc);
  assign pqc_c = 56'(max_accel) * 56'(s3_tmc);

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ctx  <= s3_ctx;
      s4_lina <= pla_c[55:16];
      s4_qa   <= pqa_c[55:24];
      s4_linb <= plb_c[63:16];
      s4_linc <= plc_c[63:16];
      s4_qc   <= pqc_c[55:24];
      s4_tma  <= s3_tma;
      s4_tmc  <= s3_tmc;
      s4_vneg <= s3_vneg;
      s4_bneg <= s3_bneg;
      s4_qcon <= s3_qc;
    end
  end

  // stage 5: quadratic terms
  logic [63:0] pqqa_c;
  logic [63:0] pqqc_c;
  ctx_t        s5_ctx;
  logic [39:0] s5_lina;
  logic [47:0] s5_linb;
  logic [47:0] s5_linc;
  logic [46:0] s5_quada;
  logic [46:0] s5_quadc;
  logic        s5_vneg;
  logic        s5_bneg;
  logic        s5_qcon;

  assign pqqa_c = 64'(s4_qa) * 64'(s4_tma);
  assign pqqc_c = 64'(s4_qc) * 64'(s4_tmc);

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ctx   <= s4_ctx;
      s5_lina  <= s4_lina;
      s5_linb  <= s4_linb;
      s5_linc  <= s4_linc;
      s5_quada <= pqqa_c[63:17];
      s5_quadc <= pqqc_c[63:17];
      s5_vneg  <= s4_vneg;
      s5_bneg  <= s4_bneg;
      s5_qcon  <= s4_qcon;
    end
  end

  // stage 6: partial sums
  ctx_t               s6_ctx;
  logic signed [51:0] s6_pa;
  logic signed [51:0] s6_pb;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_ctx <= s5_ctx;
      s6_pa  <= sgn52(1'b0, 51'(s5_lina)) + sgn52(accel_time[31], 51'(s5_quada))
              + sgn52(s5_bneg, 51'(s5_linb));
      s6_pb  <= sgn52(s5_vneg, 51'(s5_linc))
              + (s5_qcon ? sgn52(decel_time[31], 51'(s5_quadc)) : 52'sd0);
    end
  end

  // stage 7: position
  ctx_t               s7_ctx;
  logic signed [51:0] s7_pos;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_ctx <= s6_ctx;
      s7_pos <= s6_pa + s6_pb;
    end
  end

  // stage 8: magnitude and range check, divider seed
  logic [51:0] pmag_c;
  div_t        dq [DIV_STG+1];

  assign pmag_c = s7_pos[51] ? 52'(-s7_pos) : 52'(s7_pos);

  always_ff @(posedge clk) begin
    if (adv) begin
      dq[0].ctx <= s7_ctx;
      dq[0].neg <= s7_pos[51];
      dq[0].sat <= pmag_c >= {19'd0, total_distance, 1'b0};
      dq[0].rem <= pmag_c[33:0];
      dq[0].quo <= '0;
    end
  end

  // divider: one quotient bit per stage
  for (genvar j = 0; j < DIV_STG; j++) begin : g_div
    logic [33:0] r2;
    logic        ge;

    assign r2 = (j == 0) ? dq[j].rem : {dq[j].rem[32:0], 1'b0};
    assign ge = r2 >= {2'b00, total_distance};

    always_ff @(posedge clk) begin
      if (adv) begin
        dq[j+1].ctx <= dq[j].ctx;
        dq[j+1].neg <= dq[j].neg;
        dq[j+1].sat <= dq[j].sat;
        dq[j+1].rem <= ge ? (r2 - {2'b00, total_distance}) : r2;
        dq[j+1].quo <= {dq[j].quo[FRAC_W-2:0], ge};
      end
    end
  end

  // final stage: snap, saturate, bypass
  div_t        df;
  logic [17:0] rmag_c;
  logic        rneg_c;
  out_item_t   res_c;

  assign df     = dq[DIV_STG];
  assign rmag_c = df.sat ? TWO_Q16 : {1'b0, df.quo};
  assign rneg_c = df.neg && (rmag_c != '0);

  always_comb begin
    res_c = '0;
    if (df.ctx.byp) begin
      if (18'(df.ctx.frac) > ONE_Q16) begin
        res_c.distance_fraction = ONE_Q16[FRAC_W-1:0];
        res_c.out_of_range      = 1'b1;
      end else begin
        res_c.distance_fraction = df.ctx.frac;
      end
    end else begin
      priority if (rmag_c < TOL) begin
        res_c.distance_fraction = '0;
      end else if (rneg_c) begin
        res_c.out_of_range = 1'b1;
      end else if (rmag_c >= ONE_Q16 && rmag_c < ONE_TOL) begin
        res_c.distance_fraction = ONE_Q16[FRAC_W-1:0];
      end else if (rmag_c > ONE_Q16) begin
        res_c.distance_fraction = ONE_Q16[FRAC_W-1:0];
        res_c.out_of_range      = 1'b1;
      end else begin
        res_c.distance_fraction = rmag_c[FRAC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= res_c;
    end
  end

  assign out_valid = vld[NSTG-1];

  `ASSERT_IMPLIES(a_flag_clamped, out_valid && out_item.out_of_range,
    out_item.distance_fraction == '0 || out_item.distance_fraction == ONE_Q16[FRAC_W-1:0])
  `ASSERT_IMPLIES(a_frac_range, out_valid,
    18'(out_item.distance_fraction) <= ONE_Q16)
  `ASSERT_NEXT(a_hold_on_stall, !adv, vld == $past(vld))

endmodule
